// File: hdl/histogram_range_integrator_top_assert.svh
// ----------------------------------------------------------------------------
// Histogram range integrator assertion macros
// Concurrent assertion helpers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_RANGE_INTEGRATOR_TOP_ASSERT_SVH
`define HISTOGRAM_RANGE_INTEGRATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HRI_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("hri assertion failed");
`define HRI_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hri assertion failed");
`else
`define HRI_ASSERT_NEVER(label, clk, rstn, cond)
`define HRI_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/hri_pkg.sv
// ----------------------------------------------------------------------------
// Histogram range integrator package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package hri_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_UNB   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_UNB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PARTIAL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISTRIB     = 3'd5;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FULL,
    OP_WIDTH,
    OP_FRAC
  } op_e;

  typedef struct packed {
    logic signed [31:0] edge_left;
    logic signed [31:0] edge_right;
    logic signed [31:0] count_value;
    logic signed [31:0] error_value;
    logic               last_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] integral;
    logic        [31:0] integral_error;
    logic signed [31:0] edge_start;
    logic signed [31:0] edge_end;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] edge_left;
    logic signed [31:0] edge_right;
    logic        [31:0] y_mag;
    logic        [31:0] e_mag;
    logic               y_neg;
    logic               last_bin;
    op_e                op;
    logic        [31:0] mul_b;
    logic        [31:0] div_w;
    logic               l_start;
    logic               r_start;
    logic               l_end;
    logic               r_end;
    logic               start_lim;
    logic               end_lim;
    logic signed [31:0] lim_lo;
    logic signed [31:0] lim_hi;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/histogram_range_integrator_top.sv
// ----------------------------------------------------------------------------
// Histogram range integrator
// Integrates one spectrum of bins over a configurable range.
//
//   Channel   Direction  Handshake                Payload
//   in        sink       in_valid_i / in_stall_o  in_data_i   (in_item_t)
//   out       source     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// In the back end a bin outside the range passes through the finish state only,
// a full or width weighted bin through the multiply, square, accumulate and
// finish states, and a partial bin in count mode runs a bit-serial weight division first.
// A last bin that yields a result then runs a bit-serial square root of the error sum.
// A two-entry queue takes bins while the back end works; in_stall_o is high
// while it is full. Reset is asynchronous and active low.
// ----------------------------------------------------------------------------
`include "histogram_range_integrator_top_assert.svh"

module histogram_range_integrator_top #(
  parameter int SAMPLE_WIDTH = hri_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hri_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hri_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hri_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import hri_pkg::*;

  cls_t    cls, q_data;
  q_stat_t q_stat;
  logic    q_push, q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat.full;
  assign q_push      = in_valid_i && !q_stat.full;

  hri_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_data_i),
    .cls_o       (cls)
  );

  hri_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (cls),
    .pop_i  (q_pop),
    .data_o (q_data),
    .stat_o (q_stat)
  );

  hri_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (q_data),
    .entry_valid_i (!q_stat.empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  `HRI_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && q_stat.empty)
  `HRI_ASSERT_IMPLY(a_full_not_empty, clk_i, rst_ni, q_stat.full, !q_stat.empty)
  `HRI_ASSERT_IMPLY(a_pop_frees, clk_i, rst_ni, q_pop && q_stat.full && !q_push, ##1 !q_stat.full)

endmodule

// File: hdl/hri_front.sv
// ----------------------------------------------------------------------------
// Histogram range integrator front end
// Holds the configuration and classifies each incoming bin against the range.
// ----------------------------------------------------------------------------
module hri_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [hri_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  hri_pkg::in_item_t                  item_i,
  output hri_pkg::cls_t                      cls_o
);
  import hri_pkg::*;

  logic signed [31:0] lower_q, upper_q;
  logic               lower_unb_q, upper_unb_q, partial_q, distrib_q;

  logic signed [32:0] lo, hi, l_ext, r_ext, w, a, b, ov;
  logic        [32:0] y_negated, e_negated;
  logic               full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q     <= '0;
      upper_q     <= '0;
      lower_unb_q <= 1'b1;
      upper_unb_q <= 1'b1;
      partial_q   <= 1'b0;
      distrib_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RANGE_LOWER: lower_q     <= cfg_data_i;
        REG_RANGE_UPPER: upper_q     <= cfg_data_i;
        REG_LOWER_UNB:   lower_unb_q <= cfg_data_i[0];
        REG_UPPER_UNB:   upper_unb_q <= cfg_data_i[0];
        REG_PARTIAL:     partial_q   <= cfg_data_i[0];
        REG_DISTRIB:     distrib_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    lo    = {lower_q[31], lower_q};
    hi    = {upper_q[31], upper_q};
    if (!lower_unb_q && !upper_unb_q && (hi < lo)) begin
      hi = '0;
    end
    l_ext = {item_i.edge_left[31], item_i.edge_left};
    r_ext = {item_i.edge_right[31], item_i.edge_right};
    w     = r_ext - l_ext;
    full  = (lower_unb_q || (l_ext >= lo)) && (upper_unb_q || (r_ext <= hi));
    a     = (!lower_unb_q && (lo > l_ext)) ? lo : l_ext;
    b     = (!upper_unb_q && (hi < r_ext)) ? hi : r_ext;
    ov    = b - a;

    y_negated = -{item_i.count_value[31], item_i.count_value};
    e_negated = -{item_i.error_value[31], item_i.error_value};

    cls_o.edge_left  = item_i.edge_left;
    cls_o.edge_right = item_i.edge_right;
    cls_o.y_mag      = item_i.count_value[31] ? y_negated[31:0] : item_i.count_value;
    cls_o.e_mag      = item_i.error_value[31] ? e_negated[31:0] : item_i.error_value;
    cls_o.y_neg      = item_i.count_value[31];
    cls_o.last_bin   = item_i.last_bin;
    cls_o.op         = OP_NONE;
    cls_o.mul_b      = '0;
    cls_o.div_w      = w[31:0];
    if (w > 0) begin
      if (full) begin
        cls_o.op    = distrib_q ? OP_WIDTH : OP_FULL;
        cls_o.mul_b = distrib_q ? w[31:0] : 32'h0001_0000;
      end else if (partial_q && (ov > 0)) begin
        cls_o.op    = distrib_q ? OP_WIDTH : OP_FRAC;
        cls_o.mul_b = ov[31:0];
      end
    end
    cls_o.l_start   = lower_unb_q || (l_ext >= lo);
    cls_o.r_start   = lower_unb_q || (r_ext >= lo);
    cls_o.l_end     = upper_unb_q || (l_ext <= hi);
    cls_o.r_end     = upper_unb_q || (r_ext <= hi);
    cls_o.start_lim = partial_q && !lower_unb_q;
    cls_o.end_lim   = partial_q && !upper_unb_q;
    cls_o.lim_lo    = lo[31:0];
    cls_o.lim_hi    = hi[31:0];
  end

endmodule

// File: hdl/hri_queue.sv
// ----------------------------------------------------------------------------
// Histogram range integrator queue
// Short register queue of classified bins between the front and back end.
// ----------------------------------------------------------------------------
module hri_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hri_pkg::cls_t     data_i,
  input  logic              pop_i,
  output hri_pkg::cls_t     data_o,
  output hri_pkg::q_stat_t  stat_o
);
  import hri_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// File: hdl/hri_back.sv
// ----------------------------------------------------------------------------
// Histogram range integrator back end
// Weights each bin, accumulates the sums and produces the spectrum result.
// ----------------------------------------------------------------------------
module hri_back #(
  parameter int SAMPLE_WIDTH = hri_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hri_pkg::cls_t      entry_i,
  input  logic               entry_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hri_pkg::out_item_t out_data_o
);
  import hri_pkg::*;

  localparam int WF    = SAMPLE_WIDTH - 16;
  localparam int FW    = (WF > 0) ? WF : 1;
  localparam int CW    = $clog2(WF + 2);
  localparam int SHL   = (WF <= 16) ? 16 - WF : 0;
  localparam int SHR   = (WF > 16) ? WF - 16 : 0;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MC   = 3'd2;
  localparam logic [2:0] S_ME   = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_SQRT = 3'd7;

  logic [2:0]         state_q, state_d;
  logic               out_valid_q, out_valid_d;
  cls_t               e_q, e_d;
  logic [31:0]        b_q, b_d;
  logic [32:0]        r_q, r_d;
  logic [FW-1:0]      f_q, f_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [63:0]        prod_q, prod_d;
  logic [63:0]        cmag_q, cmag_d;
  logic               eovf_q, eovf_d;
  logic signed [63:0] csum_q, csum_d;
  logic [63:0]        esum_q, esum_d;
  logic signed [31:0] start_q, start_d, end_q, end_d;
  logic               found_q, found_d, below_q, below_d;
  logic               first_q, first_d, clip_q, clip_d;
  logic [63:0]        sx_q, sx_d, sres_q, sres_d, sbit_q, sbit_d;
  out_item_t          out_q, out_d;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        product;
  logic [33:0]        r_shift;
  logic [63:0]        errq;
  logic signed [65:0] c_add, c_term;
  logic [64:0]        e_add;
  logic [63:0]        s_try;

  assign product = mul_a * mul_b;

  always_comb begin
    mul_a = e_q.y_mag;
    mul_b = b_q;
    case (state_q)
      S_ME: begin
        mul_a = e_q.e_mag;
      end
      S_SQ: begin
        mul_a = errq[31:0];
        mul_b = errq[31:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    e_d         = e_q;
    b_d         = b_q;
    r_d         = r_q;
    f_d         = f_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    cmag_d      = cmag_q;
    eovf_d      = eovf_q;
    csum_d      = csum_q;
    esum_d      = esum_q;
    start_d     = start_q;
    end_d       = end_q;
    found_d     = found_q;
    below_d     = below_q;
    first_d     = first_q;
    clip_d      = clip_q;
    sx_d        = sx_q;
    sres_d      = sres_q;
    sbit_d      = sbit_q;
    out_d       = out_q;
    pop_o       = 1'b0;

    r_shift = {r_q, 1'b0};
    errq    = (e_q.op == OP_FRAC) ? (prod_q >> WF) : (prod_q >> 16);
    c_term  = e_q.y_neg ? -$signed({2'b00, cmag_q}) : $signed({2'b00, cmag_q});
    c_add   = $signed({{2{csum_q[63]}}, csum_q}) + c_term;
    e_add   = {1'b0, esum_q} + {1'b0, prod_q};
    s_try   = sres_q + sbit_q;

    case (state_q)
      S_IDLE: begin
        if (out_valid_q && !out_stall_i) begin
          out_valid_d = 1'b0;
        end
        if (entry_valid_i && !(out_valid_q && out_stall_i)) begin
          pop_o   = 1'b1;
          e_d     = entry_i;
          b_d     = entry_i.mul_b;
          r_d     = {1'b0, entry_i.mul_b};
          f_d     = '0;
          cnt_d   = '0;
          found_d = found_q;
          below_d = below_q;
          if (first_q) begin
            csum_d  = '0;
            esum_d  = '0;
            start_d = '0;
            end_d   = '0;
            found_d = 1'b0;
            below_d = 1'b0;
            clip_d  = 1'b0;
            first_d = 1'b0;
          end
          if (!found_d && entry_i.l_start) begin
            start_d = entry_i.edge_left;
            found_d = 1'b1;
          end else if (!found_d && entry_i.r_start) begin
            start_d = entry_i.edge_right;
            found_d = 1'b1;
          end
          if (entry_i.r_end) begin
            end_d = entry_i.edge_right;
          end else if (entry_i.l_end) begin
            end_d = entry_i.edge_left;
          end
          below_d = below_d || entry_i.l_end || entry_i.r_end;
          case (entry_i.op)
            OP_NONE: state_d = S_FIN;
            OP_FRAC: begin
              if (WF > 0) begin
                state_d = S_DIV;
              end else begin
                b_d     = '0;
                state_d = S_MC;
              end
            end
            default: state_d = S_MC;
          endcase
        end
      end
      S_DIV: begin
        if (r_shift >= {2'b00, e_q.div_w}) begin
          r_d = 33'(r_shift - {2'b00, e_q.div_w});
          f_d = (f_q << 1) | FW'(1);
        end else begin
          r_d = r_shift[32:0];
          f_d = f_q << 1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(WF - 1)) begin
          state_d = S_MC;
          b_d     = 32'(f_d);
        end
      end
      S_MC: begin
        prod_d  = product;
        state_d = S_ME;
      end
      S_ME: begin
        cmag_d  = (e_q.op == OP_FRAC) ? ((prod_q << SHL) >> SHR) : prod_q;
        prod_d  = product;
        state_d = S_SQ;
      end
      S_SQ: begin
        eovf_d = |errq[63:32];
        prod_d = product;
        if (c_add > $signed({3'b000, {63{1'b1}}})) begin
          csum_d = {1'b0, {63{1'b1}}};
          clip_d = 1'b1;
        end else if (c_add < $signed({3'b111, {63{1'b0}}})) begin
          csum_d = {1'b1, {63{1'b0}}};
          clip_d = 1'b1;
        end else begin
          csum_d = c_add[63:0];
        end
        state_d = S_ACC;
      end
      S_ACC: begin
        if (eovf_q || e_add[64]) begin
          esum_d = '1;
          clip_d = 1'b1;
        end else begin
          esum_d = e_add[63:0];
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
        if (e_q.last_bin) begin
          first_d = 1'b1;
          if (found_q && below_q) begin
            sx_d    = esum_q;
            sres_d  = '0;
            sbit_d  = 64'h4000_0000_0000_0000;
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (sbit_q == '0) begin
          if (!(out_valid_q && out_stall_i)) begin
            out_d.integral       = csum_q;
            out_d.integral_error = sres_q[31:0];
            out_d.edge_start     = e_q.start_lim ? e_q.lim_lo : start_q;
            out_d.edge_end       = e_q.end_lim ? e_q.lim_hi : end_q;
            out_d.saturated      = clip_q;
            out_valid_d          = 1'b1;
            state_d              = S_IDLE;
          end
        end else begin
          if (sx_q >= s_try) begin
            sx_d   = sx_q - s_try;
            sres_d = (sres_q >> 1) + sbit_q;
          end else begin
            sres_d = sres_q >> 1;
          end
          sbit_d = sbit_q >> 2;
        end
        if (out_valid_q && !out_stall_i && (sbit_q != '0)) begin
          out_valid_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if ((state_q != S_IDLE) && (state_q != S_SQRT) && out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      csum_q      <= '0;
      esum_q      <= '0;
      start_q     <= '0;
      end_q       <= '0;
      found_q     <= 1'b0;
      below_q     <= 1'b0;
      first_q     <= 1'b1;
      clip_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      csum_q      <= csum_d;
      esum_q      <= esum_d;
      start_q     <= start_d;
      end_q       <= end_d;
      found_q     <= found_d;
      below_q     <= below_d;
      first_q     <= first_d;
      clip_q      <= clip_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    b_q    <= b_d;
    r_q    <= r_d;
    f_q    <= f_d;
    prod_q <= prod_d;
    cmag_q <= cmag_d;
    eovf_q <= eovf_d;
    sx_q   <= sx_d;
    sres_q <= sres_d;
    sbit_q <= sbit_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/histogram_range_integrator_top_tb.sv
// ----------------------------------------------------------------------------
// Histogram range integrator testbench
// Streams spectra of bins through the integrator under changing range and
// mode settings and compares every result with a cycle-free predictor of the
// integral, the error root and the edges used. It runs a directed part, a
// random part under several idling patterns, and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module histogram_range_integrator_top_tb;
  import hri_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int WF = SW - 16;
  localparam int DRAIN_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic signed [64:0] I64_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] I64_MIN = -65'sh0_8000_0000_0000_0000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_RANGE_LOWER;
  logic [31:0] cfg_data_i = '0;

  histogram_range_integrator_top #(.SAMPLE_WIDTH(SW)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor configuration and state.
  logic signed [31:0] lim_lower = '0, lim_upper = '0;
  bit lower_open = 1, upper_open = 1, partial_on = 0, density_on = 0;
  logic signed [63:0] count_acc;
  logic [63:0] err_sq_acc;
  logic signed [63:0] start_edge, end_edge;
  bit start_seen, spectrum_fresh = 1, end_seen, clipped;

  out_item_t integral_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;
  int sent_bins = 0;
  int quiet_cycles = 0;

  function automatic void add_count(logic [63:0] mag, bit neg);
    logic signed [64:0] t, s;
    if (neg) begin
      if (mag == 0) t = 0;
      else if ({1'b0, mag} > I64_MAX) t = I64_MIN;
      else t = -$signed({1'b0, mag});
    end else if ({1'b0, mag} > I64_MAX) begin
      t = I64_MAX;
      clipped = 1;
    end else begin
      t = $signed({1'b0, mag});
    end
    s = count_acc + t;
    if (s > I64_MAX) begin
      count_acc = I64_MAX[63:0];
      clipped = 1;
    end else if (s < I64_MIN) begin
      count_acc = I64_MIN[63:0];
      clipped = 1;
    end else begin
      count_acc = s[63:0];
    end
  endfunction

  function automatic void add_error(logic [63:0] q16);
    logic [64:0] s;
    if (q16[63:32] != 0) begin
      err_sq_acc = '1;
      clipped = 1;
    end else begin
      s = err_sq_acc + q16 * q16;
      if (s[64]) begin
        err_sq_acc = '1;
        clipped = 1;
      end else begin
        err_sq_acc = s[63:0];
      end
    end
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] x);
    logic [63:0] r, c;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= x) r = c;
    end
    return r[31:0];
  endfunction

  function automatic void note_edge(logic signed [63:0] e, logic signed [63:0] lo,
                                    logic signed [63:0] hi);
    if (!start_seen && (lower_open || e >= lo)) begin
      start_seen = 1;
      start_edge = e;
    end
    if (upper_open || e <= hi) begin
      end_seen = 1;
      end_edge = e;
    end
  endfunction

  function automatic void predict_bin(in_item_t b);
    logic signed [63:0] l, r, y, e, lo, hi, w, a, z;
    logic [63:0] ym, em, ov, rem, f, m;
    out_item_t res;
    l = b.edge_left;
    r = b.edge_right;
    y = b.count_value;
    e = b.error_value;
    lo = lim_lower;
    hi = lim_upper;
    w = r - l;
    ym = y < 0 ? -y : y;
    em = e < 0 ? -e : e;
    if (!lower_open && !upper_open && hi < lo) hi = 0;
    if (spectrum_fresh) begin
      count_acc = 0;
      err_sq_acc = 0;
      start_edge = 0;
      end_edge = 0;
      start_seen = 0;
      end_seen = 0;
      clipped = 0;
      spectrum_fresh = 0;
    end
    if (w > 0) begin
      if ((lower_open || l >= lo) && (upper_open || r <= hi)) begin
        if (density_on) begin
          add_count(ym * w, y < 0);
          add_error((em * w) >> 16);
        end else begin
          add_count(ym << 16, y < 0);
          add_error(em);
        end
      end else if (partial_on) begin
        a = (!lower_open && lo > l) ? lo : l;
        z = (!upper_open && hi < r) ? hi : r;
        if (z > a) begin
          ov = z - a;
          if (density_on) begin
            add_count(ym * ov, y < 0);
            add_error((em * ov) >> 16);
          end else begin
            rem = ov;
            f = 0;
            for (int i = 0; i < WF; i++) begin
              rem = rem << 1;
              f = f << 1;
              if (rem >= w) begin
                rem = rem - w;
                f[0] = 1'b1;
              end
            end
            m = ym * f;
            if (WF <= 16) m = m << (16 - WF);
            else m = m >> (WF - 16);
            add_count(m, y < 0);
            add_error((em * f) >> WF);
          end
        end
      end
    end
    note_edge(l, lo, hi);
    note_edge(r, lo, hi);
    if (b.last_bin) begin
      spectrum_fresh = 1;
      if (start_seen && end_seen) begin
        res.integral = count_acc;
        res.integral_error = floor_root(err_sq_acc);
        res.edge_start = (partial_on && !lower_open) ? lo[31:0] : start_edge[31:0];
        res.edge_end = (partial_on && !upper_open) ? hi[31:0] : end_edge[31:0];
        res.saturated = clipped;
        integral_q.push_back(res);
      end
    end
  endfunction

  // Receiver side: random stalls, or a counted hold-off when requested.
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      out_stall_i = 1'b1;
      stall_hold--;
    end else begin
      out_stall_i = $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (integral_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", out_data_o);
      end else begin
        want = integral_q.pop_front();
        if (out_data_o.integral !== want.integral
            || out_data_o.integral_error !== want.integral_error
            || out_data_o.edge_start !== want.edge_start
            || out_data_o.edge_end !== want.edge_end
            || out_data_o.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("histogram_range_integrator_top_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // All tasks start and end at a falling edge.
  task automatic send_bin(logic signed [31:0] l, logic signed [31:0] r,
                          logic signed [31:0] y, logic signed [31:0] e, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = '{edge_left: l, edge_right: r, count_value: y, error_value: e,
                  last_bin: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_bin(in_data_i);
    sent_bins++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (integral_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_RANGE_LOWER: lim_lower = val;
      REG_RANGE_UPPER: lim_upper = val;
      REG_LOWER_UNB: lower_open = val[0];
      REG_UPPER_UNB: upper_open = val[0];
      REG_PARTIAL: partial_on = val[0];
      REG_DISTRIB: density_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_range(logic signed [31:0] lo, logic signed [31:0] hi, bit lo_open,
                           bit hi_open, bit part, bit dens);
    wait_idle();
    write_reg(REG_RANGE_LOWER, lo);
    write_reg(REG_RANGE_UPPER, hi);
    write_reg(REG_LOWER_UNB, {31'($urandom()), lo_open});
    write_reg(REG_UPPER_UNB, {31'($urandom()), hi_open});
    write_reg(REG_PARTIAL, {31'($urandom()), part});
    write_reg(REG_DISTRIB, {31'($urandom()), dens});
  endtask

  task automatic random_range();
    logic signed [31:0] lo, hi;
    lo = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    hi = $urandom_range(3) == 0 ? lo - $urandom_range(0, 1 << 22)
                                : lo + $urandom_range(0, 1 << 24);
    if ($urandom_range(9) == 0) lo = 32'sh8000_0000;
    if ($urandom_range(9) == 0) hi = 32'sh7FFF_FFFF;
    set_range(lo, hi, $urandom_range(3) == 0, $urandom_range(3) == 0,
              $urandom_range(1), $urandom_range(1));
  endtask

  task automatic random_spectrum(int nbins);
    logic signed [63:0] x, w;
    logic signed [31:0] y, e;
    x = $signed({32'd0, $urandom_range(0, 1 << 26)}) - (1 << 25);
    for (int i = 0; i < nbins; i++) begin
      w = $urandom_range(1, 1 << $urandom_range(8, 22));
      y = $urandom_range(1) ? $urandom() : $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      e = $urandom_range(1) ? $urandom() : $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      if ($urandom_range(9) == 0)
        send_bin($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(7) == 0);
      else
        send_bin(x[31:0], x[31:0] + w[31:0], y, e, i == nbins - 1);
      x = x + w;
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_bin(0, ONE, ONE, ONE, 0);
    send_bin(ONE, 2 * ONE, -2 * ONE, 3 * ONE, 0);
    send_bin(2 * ONE, 3 * ONE, ONE + ONE / 2, -ONE, 1);
    send_bin(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
    send_bin(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
    // Zero and negative width bins add nothing but still mark edges.
    send_bin(5 * ONE, 5 * ONE, ONE, ONE, 0);
    send_bin(7 * ONE, 6 * ONE, ONE, ONE, 1);
    set_range(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 1);
    for (int i = 0; i < 3; i++)
      send_bin(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, i == 2);
    send_bin(-ONE, ONE, 32'sh8000_0000, ONE, 1);
    // Limits straddled by the outer bins.
    set_range(ONE, 3 * ONE, 0, 0, 1, 0);
    send_bin(ONE / 2, ONE + ONE / 2, 3 * ONE, ONE, 0);
    send_bin(ONE + ONE / 2, 2 * ONE + ONE / 2, -ONE, 2 * ONE, 0);
    send_bin(2 * ONE + ONE / 2, 3 * ONE + ONE / 2, 7 * ONE, -ONE, 1);
    // Whole range inside one bin.
    set_range(ONE + ONE / 4, ONE + ONE / 2, 0, 0, 1, 1);
    send_bin(ONE, 2 * ONE, 5 * ONE, 3 * ONE, 1);
    // Empty range: upper below lower is taken as zero.
    set_range(3 * ONE, ONE, 0, 0, 1, 0);
    send_bin(-ONE, 4 * ONE, ONE, ONE, 1);
    send_bin(ONE, 4 * ONE, ONE, ONE, 1);
    // Spectrum wholly outside the range gives no result.
    set_range(10 * ONE, 20 * ONE, 0, 0, 0, 0);
    send_bin(0, ONE, ONE, ONE, 0);
    send_bin(ONE, 2 * ONE, ONE, ONE, 1);
    set_range(32'sh8000_0000, 0, 1, 0, 0, 0);
    send_bin(ONE, 2 * ONE, ONE, ONE, 1);
  endtask

  task automatic test_random(int send_pct, int recv_pct, int nbins);
    int target;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    target = sent_bins + nbins;
    while (sent_bins < target) begin
      if ($urandom_range(2) == 0) random_range();
      random_spectrum($urandom_range(1, 10));
    end
  endtask

  task automatic test_hold_off();
    set_range(0, 0, 1, 1, 0, 0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_hold = 400;
    for (int i = 0; i < 6; i++) begin
      send_bin(i * ONE, (i + 1) * ONE, ONE, ONE, 1);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(0, 0, 150);
    test_random(76, 0, 150);
    test_random(0, 76, 150);
    test_random(21, 21, 150);
    test_hold_off();
    test_random(0, 0, 150);
    wait_idle();
    if (mismatches == 0 && integral_q.size() == 0) begin
      $display("histogram_range_integrator_top_tb: PASS");
    end else begin
      $display("histogram_range_integrator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
